// ===== sv/imhq_pkg.sv =====
// Package for the indexed min-heap queue: widths, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;
  localparam int HeapDepth    = 255;
  localparam int IdCount      = 256;
  localparam int PrioBits     = 32;
  localparam int SlotW        = $clog2(HeapDepth);
  localparam int CntW         = $clog2(HeapDepth + 1);
  localparam int IdW          = $clog2(IdCount);
  localparam int EntryW       = IdW + PrioBits;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_REKEY   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [PrioBits-1:0] key;
  } entry_t;
endpackage
`default_nettype wire

// ===== sv/imhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module imhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/indexed_min_heap_queue_top.sv =====
// Top level of the indexed min-heap queue: sequencer, heap and position memories.
// Sequence: rejected commands go straight to the result; insert sifts the new entry up;
//   delete, extract and rekey sift the entry up, or down if it did not climb, in the
//   255-entry heap.
// Throughput: one command at a time; in_tready is low from acceptance until the result
//   is loaded into the output register, which waits while an earlier result is held.
//   The heap memory's single read port means parent and children are read one at a time.
// Reset (rst_n, synchronous, active low) clears occupancy, presence bits, the
//   sequencer and the output valid flag; cap_r returns to 255.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_top
  import imhq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // command[1:0], item_id[9:2], priority_req[41:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // status[2:0], min_id[10:3], min_priority[42:11],
                                       // entry_count[50:43], heap_empty[51]
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_RDLAST = 11'b00000000100,
    S_PLACE  = 11'b00000001000,
    S_UPRD   = 11'b00000010000,
    S_UPCMP  = 11'b00000100000,
    S_DNRDL  = 11'b00001000000,
    S_DNRDR  = 11'b00010000000,
    S_DNCMP  = 11'b00100000000,
    S_ROOT   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  localparam logic [PrioBits-1:0] SignBit = {1'b1, {(PrioBits-1){1'b0}}};

  state_t              state_r, state_nxt;
  logic [7:0]          cap_r;
  logic [CntW-1:0]     occ_r, occ_nxt;
  logic [IdCount-1:0]  pres_r, pres_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [IdW-1:0]      id_r, id_nxt;
  logic [PrioBits-1:0] key_r, key_nxt;
  status_t             st_r, st_nxt;
  entry_t              cur_r, cur_nxt;      // entry being sifted
  logic [SlotW-1:0]    pos_r, pos_nxt;      // its slot
  logic                dn_r, dn_nxt;        // sift down after sifting up
  entry_t              lch_r, lch_nxt;
  logic                out_v_r, out_v_nxt;
  logic [55:0]         out_d_r, out_d_nxt;

  // heap memory
  logic             h_we;
  logic [SlotW-1:0] h_wa, h_ra;
  entry_t           h_wd, h_rd;
  // position memory
  logic             p_we;
  logic [IdW-1:0]   p_wa, p_ra;
  logic [SlotW-1:0] p_wd, p_rd;

  imhq_ram #(.Width(EntryW), .Depth(HeapDepth)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  imhq_ram #(.Width(SlotW), .Depth(IdCount)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );

  logic [CntW-1:0] cap_eff;
  logic [CntW:0]   lidx, ridx;
  logic [CntW-1:0] par;
  logic            lt;
  entry_t          rch;

  assign cap_eff = (CntW'(cap_r) > CntW'(HeapDepth)) ? CntW'(HeapDepth) : CntW'(cap_r);
  assign lidx = {pos_r, 1'b1};
  assign ridx = lidx + 1'b1;
  assign par  = (CntW'(pos_r) - 1'b1) >> 1;
  assign rch  = h_rd;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 8'd255;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r; pres_nxt = pres_r; cmd_nxt = cmd_r; id_nxt = id_r;
    key_nxt = key_r; st_nxt = st_r; cur_nxt = cur_r; pos_nxt = pos_r;
    dn_nxt = dn_r; lch_nxt = lch_r; out_v_nxt = out_v_r; out_d_nxt = out_d_r;
    h_we = 1'b0; h_wa = pos_r; h_wd = cur_r; h_ra = pos_r;
    p_we = 1'b0; p_wa = cur_r.id; p_wd = pos_r; p_ra = id_r;
    lt = 1'b0;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        p_ra = in_tdata[9:2];
        if (in_tvalid) begin
          cmd_nxt = cmd_t'(in_tdata[1:0]);
          id_nxt = in_tdata[9:2];
          key_nxt = in_tdata[41:10] ^ SignBit;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        // p_rd holds slot of id_r
        st_nxt = ST_OK;
        dn_nxt = 1'b1;
        state_nxt = S_ROOT;
        if (cmd_r == CMD_INSERT) begin
          if (occ_r >= cap_eff) st_nxt = ST_FULL;
          else if (pres_r[id_r]) st_nxt = ST_DUP;
          else begin
            pres_nxt[id_r] = 1'b1;
            cur_nxt = '{id: id_r, key: key_r};
            pos_nxt = SlotW'(occ_r);
            occ_nxt = occ_r + 1'b1;
            dn_nxt = 1'b0;
            state_nxt = S_UPRD;
          end
        end else if (occ_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (cmd_r != CMD_EXTRACT && !pres_r[id_r]) begin
          st_nxt = ST_ABSENT;
        end else begin
          pos_nxt = (cmd_r == CMD_EXTRACT) ? '0 : p_rd;
          if (cmd_r == CMD_REKEY) begin
            cur_nxt = '{id: id_r, key: key_r};
            state_nxt = S_UPRD;
          end else begin
            h_ra = (cmd_r == CMD_EXTRACT) ? '0 : p_rd;
            state_nxt = S_RDLAST;
          end
        end
      end
      S_RDLAST: begin
        // h_rd is the removed entry
        pres_nxt[h_rd.id] = 1'b0;
        occ_nxt = occ_r - 1'b1;
        h_ra = SlotW'(occ_r - 1'b1);
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cur_nxt = h_rd;
        if (CntW'(pos_r) < occ_r) state_nxt = S_UPRD;
        else state_nxt = S_ROOT;
      end
      S_UPRD: begin
        h_ra = SlotW'(par);
        if (pos_r == '0) state_nxt = dn_r ? S_DNRDL : S_ROOT;
        else state_nxt = S_UPCMP;
        if (pos_r == '0) begin
          h_we = 1'b1; p_we = 1'b1;
        end
      end
      S_UPCMP: begin
        if (cur_r.key < h_rd.key) begin
          // move parent down into this slot
          h_we = 1'b1; h_wd = h_rd; p_we = 1'b1; p_wa = h_rd.id;
          pos_nxt = SlotW'(par);
          dn_nxt = 1'b0;
          state_nxt = S_UPRD;
        end else begin
          h_we = 1'b1; p_we = 1'b1;
          state_nxt = dn_r ? S_DNRDL : S_ROOT;
        end
      end
      S_DNRDL: begin
        h_ra = SlotW'(lidx);
        if (lidx >= (CntW+1)'(occ_r)) begin
          h_we = 1'b1; p_we = 1'b1;
          state_nxt = S_ROOT;
        end else begin
          state_nxt = S_DNRDR;
        end
      end
      S_DNRDR: begin
        lch_nxt = h_rd;
        h_ra = SlotW'(ridx);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        entry_t c;
        logic [SlotW-1:0] ci;
        c = lch_r; ci = SlotW'(lidx);
        if (ridx < (CntW+1)'(occ_r) && !(lch_r.key < rch.key)) begin
          c = rch; ci = SlotW'(ridx);
        end
        lt = cur_r.key > c.key;
        if (lt) begin
          h_we = 1'b1; h_wd = c; p_we = 1'b1; p_wa = c.id;
          pos_nxt = ci;
          state_nxt = S_DNRDL;
        end else begin
          h_we = 1'b1; p_we = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        h_ra = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the root on the read port while the output register is busy
        h_ra = '0;
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = '0;
          out_d_nxt[2:0] = st_r;
          out_d_nxt[50:43] = 8'(occ_r);
          if (occ_r == '0) begin
            out_d_nxt[51] = 1'b1;
          end else begin
            out_d_nxt[10:3] = 8'(h_rd.id);
            out_d_nxt[42:11] = 32'(h_rd.key ^ SignBit);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r <= '0;
      pres_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt;
      pres_r <= pres_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; id_r <= id_nxt; key_r <= key_nxt; st_r <= st_nxt;
    cur_r <= cur_nxt; pos_r <= pos_nxt; dn_r <= dn_nxt; lch_r <= lch_nxt;
    out_d_r <= out_d_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/imhq_checker.sv =====
// Port-level checker for the indexed min-heap queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module imhq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[51] == (out_tdata[50:43] == 8'd0)))
    else $error("empty flag disagrees with count");
  a_empty_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51] |-> out_tdata[42:3] == 40'd0)
    else $error("root not zero when empty");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule

bind indexed_min_heap_queue_top imhq_checker u_imhq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
